FILE: hw/rtl/vagdec_pkg.sv
// ----------------------------------------------------------------------------
// vagdec_pkg
// Shared types and constants for the VAG ADPCM stream decoder: request
// payloads, block position codes and the prediction filter coefficients.
// ----------------------------------------------------------------------------
package vagdec_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_start;
  } in_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               last;
    logic               stream_done;
  } out_t;

  localparam logic [3:0] HDR_POS  = 4'd0;
  localparam logic [3:0] FLAG_POS = 4'd1;

  function automatic logic signed [7:0] coef_pos(input logic [3:0] filter);
    logic signed [7:0] c;
    case (filter)
      4'd1:    c = 8'sd60;
      4'd2:    c = 8'sd115;
      4'd3:    c = 8'sd98;
      4'd4:    c = 8'sd122;
      default: c = 8'sd0;
    endcase
    return c;
  endfunction

  function automatic logic signed [7:0] coef_neg(input logic [3:0] filter);
    logic signed [7:0] c;
    case (filter)
      4'd2:    c = -8'sd52;
      4'd3:    c = -8'sd55;
      4'd4:    c = -8'sd60;
      default: c = 8'sd0;
    endcase
    return c;
  endfunction

endpackage

FILE: hw/rtl/vagdec_nibble_dp.sv
// ----------------------------------------------------------------------------
// vagdec_nibble_dp
// Decodes one nibble: scales it by the block shift, adds the two weighted
// history terms in fixed point and rounds the new history to a PCM sample.
// ----------------------------------------------------------------------------
module vagdec_nibble_dp #(
  parameter int FRACTION_BITS = 8
) (
  input  logic [3:0]         nibble,
  input  logic [3:0]         shift,
  input  logic [3:0]         filter,
  input  logic signed [31:0] recent,
  input  logic signed [31:0] older,
  output logic signed [31:0] hist_new,
  output logic signed [15:0] sample
);

  localparam logic signed [33:0] HALF       = 34'sd1 <<< (FRACTION_BITS - 1);
  localparam logic signed [33:0] ROUND_MASK = (34'sd1 <<< FRACTION_BITS) - 34'sd1;

  logic signed [15:0] base;
  logic signed [31:0] base_fx;
  logic signed [7:0]  cpos;
  logic signed [7:0]  cneg;
  logic signed [39:0] prod_pos;
  logic signed [39:0] prod_neg;
  logic signed [40:0] prod_sum;
  logic signed [40:0] prod_sh;
  logic signed [33:0] rnd;
  logic signed [33:0] rnd_adj;
  logic signed [33:0] quot;

  always_comb begin
    base     = $signed({nibble, 12'b0}) >>> shift;
    base_fx  = $signed({{16{base[15]}}, base} << FRACTION_BITS);
    cpos     = vagdec_pkg::coef_pos(filter);
    cneg     = vagdec_pkg::coef_neg(filter);
    prod_pos = recent * cpos;
    prod_neg = older * cneg;
    prod_sum = {prod_pos[39], prod_pos} + {prod_neg[39], prod_neg};
    prod_sh  = prod_sum >>> 6;
    hist_new = base_fx + $signed(prod_sh[31:0]);
    rnd      = $signed({{2{hist_new[31]}}, hist_new}) + HALF;
    rnd_adj  = rnd[33] ? (rnd + ROUND_MASK) : rnd;
    quot     = rnd_adj >>> FRACTION_BITS;
    sample   = $signed(quot[15:0]);
  end

endmodule

FILE: hw/rtl/vag_adpcm_stream_decoder.sv
// ----------------------------------------------------------------------------
// vag_adpcm_stream_decoder
// Decodes a VAG ADPCM byte stream in 16-byte blocks into 16-bit PCM samples.
// ----------------------------------------------------------------------------
// Bytes enter an input register and results leave through an output
// register, so a request is taken while a finished result still waits. A
// header byte or a flag byte is consumed when it is handled; a data byte is
// held for its two samples, which go one per cycle, unless the output register
// is stalled, through the single multiply-add against the history registers,
// the second using the history that the first leaves. The first sample goes
// from the input register straight into the output register; the phase register
// then turns the held byte to its high nibble for the second sample.
module vag_adpcm_stream_decoder #(
  parameter int FRACTION_BITS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  vagdec_pkg::in_t   in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output vagdec_pkg::out_t  out_data
);

  logic                    buf_v_r;
  vagdec_pkg::in_t         buf_r;
  logic                    phase_r, phase_nxt;
  logic [3:0]              pos_r, pos_nxt;
  logic [3:0]              shift_r, shift_nxt;
  logic [3:0]              filter_r, filter_nxt;
  logic signed [31:0]      recent_r, recent_nxt;
  logic signed [31:0]      older_r, older_nxt;
  logic                    ended_r, ended_nxt;
  logic                    out_v_r;
  vagdec_pkg::out_t        out_r, out_nxt;

  logic                    eff_start;
  logic [3:0]              eff_pos;
  logic                    eff_ended;
  logic signed [31:0]      eff_recent;
  logic signed [31:0]      eff_older;
  logic [3:0]              nib;
  logic signed [31:0]      dp_hist;
  logic signed [15:0]      dp_sample;
  logic                    need_out;
  logic                    done_item;
  logic                    out_can;
  logic                    fire;
  logic                    consume;

  assign eff_start  = buf_r.stream_start && !phase_r;
  assign eff_pos    = eff_start ? 4'd0 : pos_r;
  assign eff_ended  = eff_start ? 1'b0 : ended_r;
  assign eff_recent = eff_start ? 32'sd0 : recent_r;
  assign eff_older  = eff_start ? 32'sd0 : older_r;
  assign nib        = phase_r ? buf_r.data_byte[7:4] : buf_r.data_byte[3:0];

  vagdec_nibble_dp #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_dp (
    .nibble   (nib),
    .shift    (shift_r),
    .filter   (filter_r),
    .recent   (eff_recent),
    .older    (eff_older),
    .hist_new (dp_hist),
    .sample   (dp_sample)
  );

  always_comb begin
    need_out   = 1'b0;
    done_item  = 1'b0;
    out_nxt    = '0;
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    shift_nxt  = shift_r;
    filter_nxt = filter_r;
    recent_nxt = recent_r;
    older_nxt  = older_r;
    ended_nxt  = ended_r;
    if (buf_v_r) begin
      if (phase_r) begin
        need_out       = 1'b1;
        done_item      = 1'b1;
        out_nxt.sample = dp_sample;
        out_nxt.last   = 1'b1;
        recent_nxt     = dp_hist;
        older_nxt      = recent_r;
        phase_nxt      = 1'b0;
      end else if (eff_ended) begin
        done_item = 1'b1;
      end else begin
        pos_nxt    = eff_pos + 4'd1;
        ended_nxt  = 1'b0;
        recent_nxt = eff_recent;
        older_nxt  = eff_older;
        case (eff_pos)
          vagdec_pkg::HDR_POS: begin
            done_item  = 1'b1;
            shift_nxt  = buf_r.data_byte[3:0];
            filter_nxt = buf_r.data_byte[7:4];
          end
          vagdec_pkg::FLAG_POS: begin
            done_item = 1'b1;
            if (buf_r.data_byte[0]) begin
              need_out            = 1'b1;
              out_nxt.last        = 1'b1;
              out_nxt.stream_done = 1'b1;
              ended_nxt           = 1'b1;
            end
          end
          default: begin
            need_out       = 1'b1;
            out_nxt.sample = dp_sample;
            recent_nxt     = dp_hist;
            older_nxt      = eff_recent;
            phase_nxt      = 1'b1;
          end
        endcase
      end
    end
  end

  assign out_can   = !out_v_r || out_ready;
  assign fire      = buf_v_r && (!need_out || out_can);
  assign consume   = fire && done_item;
  assign in_ready  = !buf_v_r || consume;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_v_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      buf_v_r <= 1'b1;
    end else if (consume) begin
      buf_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      buf_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= 1'b0;
      pos_r    <= 4'd0;
      shift_r  <= 4'd0;
      filter_r <= 4'd0;
      recent_r <= 32'sd0;
      older_r  <= 32'sd0;
      ended_r  <= 1'b0;
    end else if (fire) begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      shift_r  <= shift_nxt;
      filter_r <= filter_nxt;
      recent_r <= recent_nxt;
      older_r  <= older_nxt;
      ended_r  <= ended_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (fire && need_out) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && need_out) begin
      out_r <= out_nxt;
    end
  end

  a_phase_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> buf_v_r)
    else $error("second nibble pending without a held request");

  a_done_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.stream_done) |-> (out_r.sample == 16'sd0 && out_r.last))
    else $error("end result carries a sample or is not last");

  a_low_then_high: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && need_out && !done_item) |=> (phase_r && out_v_r && !out_r.last))
    else $error("low nibble issued without moving to the high nibble");

  a_ended_position: assert property (@(posedge clk) disable iff (!rst_n)
    ended_r |-> (pos_r == 4'd2 && !phase_r))
    else $error("ended stream moved its block position");

endmodule

FILE: test/vag_adpcm_stream_decoder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vag_adpcm_stream_decoder_tb
// Drives VAG ADPCM byte streams into the decoder and compares every sample
// and stream end it reports with a bit-exact predictor of the block. A
// directed part covers header, flag and nibble extremes, filters and shifts
// out of range, end of stream, and restarts in mid block. Random streams then
// follow under three patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module vag_adpcm_stream_decoder_tb;

  localparam int FRAC_BITS    = 8;
  localparam int LIVE_TARGET  = 400;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int END_FLAG_BIT = 0;
  localparam int MAX_FILTER   = 4;
  localparam int MAX_PRINTS   = 100;

  localparam int signed RECENT_WEIGHT [0:MAX_FILTER] = '{0, 60, 115, 98, 122};
  localparam int signed OLDER_WEIGHT  [0:MAX_FILTER] = '{0, 0, -52, -55, -60};

  class vag_sample_predictor;
    vagdec_pkg::out_t pending[$];
    int unsigned      mismatches;
    int unsigned      checked;
    int unsigned      stream_ends;
    logic [3:0]       position;
    logic [3:0]       shift;
    logic [3:0]       filter;
    logic [31:0]      recent;
    logic [31:0]      older;
    bit               ended;

    function new();
      mismatches  = 0;
      checked     = 0;
      stream_ends = 0;
      clear();
    endfunction

    function void clear();
      position = '0;
      shift    = '0;
      filter   = '0;
      recent   = '0;
      older    = '0;
      ended    = 1'b0;
    endfunction

    // One nibble through the two-tap predictor; history advances by one.
    function logic signed [15:0] decode_nibble(logic [3:0] nib);
      longint signed base;
      longint signed acc;
      longint signed t;
      longint signed q;
      longint signed kr;
      longint signed ko;
      logic [31:0]   h;
      kr = 0;
      ko = 0;
      if (filter <= MAX_FILTER) begin
        kr = RECENT_WEIGHT[filter];
        ko = OLDER_WEIGHT[filter];
      end
      base = (longint'($signed(nib)) * 4096) >>> shift;
      acc  = (base <<< (FRAC_BITS + 6)) + longint'($signed(recent)) * kr
             + longint'($signed(older)) * ko;
      h      = 32'(acc >>> 6);
      older  = recent;
      recent = h;
      t = longint'($signed(h)) + (longint'(1) << (FRAC_BITS - 1));
      if (t >= 0) begin
        q = t >>> FRAC_BITS;
      end else begin
        q = -((-t) >>> FRAC_BITS);
      end
      return 16'(q);
    endfunction

    // Returns 1 when the byte is consumed, 0 when it is ignored after an end.
    function bit note_request(vagdec_pkg::in_t req);
      vagdec_pkg::out_t r;
      logic [3:0]       p;
      if (req.stream_start) begin
        clear();
      end
      if (ended) begin
        return 1'b0;
      end
      p = position;
      position = position + 4'd1;
      if (p == vagdec_pkg::HDR_POS) begin
        shift  = req.data_byte[3:0];
        filter = req.data_byte[7:4];
      end else if (p == vagdec_pkg::FLAG_POS) begin
        if (req.data_byte[END_FLAG_BIT]) begin
          ended         = 1'b1;
          r.sample      = '0;
          r.last        = 1'b1;
          r.stream_done = 1'b1;
          pending.insert(pending.size(), r);
          stream_ends++;
        end
      end else begin
        r.sample      = decode_nibble(req.data_byte[3:0]);
        r.last        = 1'b0;
        r.stream_done = 1'b0;
        pending.insert(pending.size(), r);
        r.sample      = decode_nibble(req.data_byte[7:4]);
        r.last        = 1'b1;
        pending.insert(pending.size(), r);
      end
      return 1'b1;
    endfunction

    function void check_result(vagdec_pkg::out_t got);
      vagdec_pkg::out_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_PRINTS) begin
          $display("%0t: unexpected result, expected none, %s",
                   $time, "actual:");
          $display("  sample=%0d last=%0b done=%0b",
                   got.sample, got.last, got.stream_done);
        end
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= MAX_PRINTS) begin
          $display("%0t: mismatch, expected sample=%0d last=%0b done=%0b,",
                   $time, want.sample, want.last, want.stream_done);
          $display("  actual sample=%0d last=%0b done=%0b",
                   got.sample, got.last, got.stream_done);
        end
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  vagdec_pkg::in_t  in_data;
  logic             out_valid;
  logic             out_ready;
  vagdec_pkg::out_t out_data;

  vag_sample_predictor sb;
  int unsigned send_gap_pct;
  int unsigned recv_stall_pct;
  int unsigned live_bytes;
  int unsigned total_requests;
  int unsigned cycles = 0;

  vag_adpcm_stream_decoder #(
    .FRACTION_BITS(FRAC_BITS)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycles, sb.pending.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        sb.check_result(out_data);
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic set_pressure();
    if (live_bytes < LIVE_TARGET / 3) begin
      send_gap_pct   = 19;
      recv_stall_pct = 60;
    end else if (live_bytes < 2 * LIVE_TARGET / 3) begin
      send_gap_pct   = 60;
      recv_stall_pct = 19;
    end else begin
      send_gap_pct   = 0;
      recv_stall_pct = 0;
    end
  endtask

  task automatic send_byte(input logic [7:0] value, input logic start);
    vagdec_pkg::in_t req;
    req.data_byte    = value;
    req.stream_start = start;
    set_pressure();
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    total_requests++;
    if (sb.note_request(req)) begin
      live_bytes++;
    end
  endtask

  task automatic random_stream();
    int         n_blocks;
    logic [3:0] shift;
    logic [3:0] filter;
    logic [7:0] flags;
    bit         stop;
    n_blocks = $urandom_range(1, 3);
    stop     = 1'b0;
    for (int blk = 0; blk < n_blocks && !stop; blk++) begin
      shift  = ($urandom_range(99) < 80) ? 4'($urandom_range(12))
                                         : 4'($urandom_range(13, 15));
      filter = ($urandom_range(99) < 80) ? 4'($urandom_range(MAX_FILTER))
                                         : 4'($urandom_range(5, 15));
      send_byte({filter, shift}, (blk == 0) && ($urandom_range(99) < 90));
      flags = 8'($urandom_range(255));
      flags[END_FLAG_BIT] = (blk == n_blocks - 1) && ($urandom_range(99) < 60);
      send_byte(flags, 1'b0);
      if (flags[END_FLAG_BIT]) begin
        stop = 1'b1;
        repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(255)), 1'b0);
      end else begin
        for (int k = 0; k < 14; k++) begin
          send_byte(8'($urandom_range(255)), $urandom_range(99) < 2);
        end
      end
    end
    if ($urandom_range(99) < 10) begin
      repeat ($urandom_range(1, 6)) begin
        send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
      end
    end
  endtask

  initial begin
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_data        <= '0;
    live_bytes     = 0;
    total_requests = 0;
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Plain stream with flag bits other than the end flag, nibble extremes.
    send_byte(8'h00, 1'b1);
    send_byte(8'hFE, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h87, 1'b0);
    send_byte(8'h78, 1'b0);
    // Strongest filter with no shift, so samples grow past 16 bits and wrap.
    send_byte(8'h40, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h77, 1'b0);
    send_byte(8'h77, 1'b0);
    send_byte(8'h77, 1'b0);
    send_byte(8'h88, 1'b0);
    // Filter out of range with the largest shift.
    send_byte(8'hFF, 1'b1);
    send_byte(8'h02, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h81, 1'b0);
    // End of stream; the following bytes are ignored until a restart.
    send_byte(8'h3D, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'h12, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h21, 1'b1);
    send_byte(8'hFF, 1'b0);
    // Restart in the middle of a block.
    send_byte(8'h20, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h35, 1'b0);
    send_byte(8'h50, 1'b1);

    while (live_bytes < LIVE_TARGET) begin
      random_stream();
    end
    in_valid <= 1'b0;

    while (sb.pending.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d stream bytes, %0d of them decoded; %0d results checked.",
             total_requests, live_bytes, sb.checked);
    $display("Stream ends reported: %0d; mismatches: %0d.", sb.stream_ends, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
